### design/pwq_pkg.sv
package pwq_pkg;

   localparam int QueueDepthDefault  = 16;
   localparam int TaskIdWidthDefault = 8;

   localparam int ModeWidth   = 3;
   localparam int StatusWidth = 2;
   localparam int TaskWidth   = 8;
   localparam int PrioWidth   = 8;
   localparam int LabelWidth  = 32;

   typedef enum logic [ModeWidth-1:0] {
      MODE_ENQUEUE  = 3'd0,
      MODE_DEQUEUE  = 3'd1,
      MODE_REMOVE   = 3'd2,
      MODE_SEND_MATCH = 3'd3,
      MODE_RECV_MATCH = 3'd4
   } mode_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Broadcast to every cell for the transaction in flight.
   typedef struct packed {
      mode_type                mode;
      logic [PrioWidth-1:0]    prio;
      logic [LabelWidth-1:0]   label;
      logic [LabelWidth-1:0]   filter;
      logic [LabelWidth-1:0]   key;
   } cmd_type;

   // One stored entry, less its task id whose width is a parameter.
   typedef struct packed {
      logic                    valid;
      logic [PrioWidth-1:0]    prio;
      logic [LabelWidth-1:0]   label;
      logic [LabelWidth-1:0]   filter;
   } entry_type;

endpackage

### design/pwq_if.sv
interface pwq_req_if;
   import pwq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ModeWidth-1:0]   mode;
   logic [TaskWidth-1:0]   task_id;
   logic [PrioWidth-1:0]   priority_req;
   logic [LabelWidth-1:0]  msg_label;
   logic [LabelWidth-1:0]  recv_filter;
   logic [LabelWidth-1:0]  match_key;

   modport source (output valid, mode, task_id, priority_req, msg_label, recv_filter,
                   match_key, input ready);
   modport sink (input valid, mode, task_id, priority_req, msg_label, recv_filter,
                 match_key, output ready);
endinterface

interface pwq_rsp_if;
   import pwq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [StatusWidth-1:0] status;
   logic [TaskWidth-1:0]   task_out;

   modport source (output valid, status, task_out, input ready);
   modport sink (input valid, status, task_out, output ready);
endinterface

### design/pwq_cell.sv
module pwq_cell #(
   parameter int TASK_ID_WIDTH = pwq_pkg::TaskIdWidthDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pwq_pkg::cmd_type          cmd,
   input  logic [TASK_ID_WIDTH-1:0]  cmd_task,
   input  logic                      insert_en,
   input  logic                      remove_en,
   input  pwq_pkg::entry_type        left_entry,
   input  logic [TASK_ID_WIDTH-1:0]  left_task,
   input  logic                      left_lower,
   input  pwq_pkg::entry_type        right_entry,
   input  logic [TASK_ID_WIDTH-1:0]  right_task,
   input  logic                      found_in,
   input  logic [TASK_ID_WIDTH-1:0]  acc_in,
   output logic                      lower,
   output logic                      found_out,
   output logic [TASK_ID_WIDTH-1:0]  acc_out,
   output pwq_pkg::entry_type        entry_out,
   output logic [TASK_ID_WIDTH-1:0]  task_out
);
   import pwq_pkg::*;

   entry_type                 entry_ff, entry_in;
   logic [TASK_ID_WIDTH-1:0]  task_ff, task_in;
   logic                      hit;

   // Free slots count as lower, so the insertion point is where the flag first rises.
   assign lower = !entry_ff.valid || (entry_ff.prio < cmd.prio);

   always_comb begin
      case (cmd.mode)
         MODE_DEQUEUE:    hit = 1'b1;
         MODE_REMOVE:     hit = (task_ff == cmd_task);
         MODE_SEND_MATCH: hit = (cmd.key == '0) || (entry_ff.label == cmd.key);
         MODE_RECV_MATCH: hit = (entry_ff.filter == '0) || (entry_ff.filter == cmd.key);
         default:         hit = 1'b0;
      endcase
      hit = hit && entry_ff.valid;
   end

   assign found_out = found_in || hit;
   assign acc_out   = acc_in | ((hit && !found_in) ? task_ff : '0);

   always_comb begin
      entry_in = entry_ff;
      task_in  = task_ff;
      if (insert_en && lower) begin
         if (left_lower) begin
            entry_in = left_entry;
            task_in  = left_task;
         end else begin
            entry_in.valid  = 1'b1;
            entry_in.prio   = cmd.prio;
            entry_in.label  = cmd.label;
            entry_in.filter = cmd.filter;
            task_in         = cmd_task;
         end
      end else if (remove_en && found_out) begin
         // close the gap: everything from the taken entry onwards moves up one
         entry_in = right_entry;
         task_in  = right_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
      task_ff <= task_in;
   end

   assign entry_out = entry_ff;
   assign task_out  = task_ff;

endmodule

### design/priority_wait_queue_label_match.sv
// A request is captured in the idle state; the response register is loaded when
// the execute state commits its compare-and-shift pass through the row of queue
// cells. No new request is taken until that pass has committed.
// A response not taken stalls the pass until the output register frees.
// Reset (synchronous) empties the queue and clears the control state.
module priority_wait_queue_label_match #(
   parameter int QUEUE_DEPTH   = pwq_pkg::QueueDepthDefault,
   parameter int TASK_ID_WIDTH = pwq_pkg::TaskIdWidthDefault
) (
   input  logic  clock,
   input  logic  reset,
   pwq_req_if.sink   req,
   pwq_rsp_if.source rsp
);
   import pwq_pkg::*;

   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [TASK_ID_WIDTH-1:0]  id_ff, id_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [TaskWidth-1:0]      task_out_ff, task_out_in;

   logic                      req_accept;
   logic                      out_free;
   logic                      commit;
   logic                      insert_en;
   logic                      remove_en;
   logic                      full;
   logic                      found;

   entry_type                 cell_entry [QUEUE_DEPTH];
   logic [TASK_ID_WIDTH-1:0]  cell_task  [QUEUE_DEPTH];
   logic                      cell_lower [QUEUE_DEPTH];
   logic                      found_c    [QUEUE_DEPTH+1];
   logic [TASK_ID_WIDTH-1:0]  acc_c      [QUEUE_DEPTH+1];
   logic [QUEUE_DEPTH-1:0]    valid_vec;

   assign req_accept = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_EXEC;
         ST_EXEC: if (out_free)   state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: req.ready = 1'b1;
         ST_EXEC: commit    = out_free;
         default: ;
      endcase
   end

   // Take the request id down (or up) to the stored id width.
   always_comb begin
      id_in = '0;
      for (int b = 0; b < TASK_ID_WIDTH; b++) begin
         if (b < TaskWidth) id_in[b] = req.task_id[b];
      end
   end

   always_comb begin
      cmd_in.mode   = mode_type'(req.mode);
      cmd_in.prio   = req.priority_req;
      cmd_in.label  = req.msg_label;
      cmd_in.filter = req.recv_filter;
      cmd_in.key    = req.match_key;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= cmd_in;
         id_ff  <= id_in;
      end
   end

   assign found_c[0] = 1'b0;
   assign acc_c[0]   = '0;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_type                 left_entry, right_entry;
      logic [TASK_ID_WIDTH-1:0]  left_task, right_task;
      logic                      left_lower;

      if (g == 0) begin : g_head
         assign left_entry = '0;
         assign left_task  = '0;
         assign left_lower = 1'b0;
      end else begin : g_mid
         assign left_entry = cell_entry[g-1];
         assign left_task  = cell_task[g-1];
         assign left_lower = cell_lower[g-1];
      end

      if (g == QUEUE_DEPTH-1) begin : g_tail
         assign right_entry = '0;
         assign right_task  = '0;
      end else begin : g_body
         assign right_entry = cell_entry[g+1];
         assign right_task  = cell_task[g+1];
      end

      pwq_cell #(
         .TASK_ID_WIDTH (TASK_ID_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd_ff),
         .cmd_task    (id_ff),
         .insert_en   (insert_en),
         .remove_en   (remove_en),
         .left_entry  (left_entry),
         .left_task   (left_task),
         .left_lower  (left_lower),
         .right_entry (right_entry),
         .right_task  (right_task),
         .found_in    (found_c[g]),
         .acc_in      (acc_c[g]),
         .lower       (cell_lower[g]),
         .found_out   (found_c[g+1]),
         .acc_out     (acc_c[g+1]),
         .entry_out   (cell_entry[g]),
         .task_out    (cell_task[g])
      );

      assign valid_vec[g] = cell_entry[g].valid;
   end

   assign full      = valid_vec[QUEUE_DEPTH-1];
   assign found     = found_c[QUEUE_DEPTH];
   assign insert_en = commit && (cmd_ff.mode == MODE_ENQUEUE) && !full;
   assign remove_en = commit && found;

   always_comb begin
      if (cmd_ff.mode == MODE_ENQUEUE) begin
         status_in = full ? STATUS_FULL : STATUS_OK;
      end else begin
         status_in = found ? STATUS_OK : STATUS_NONE;
      end
      task_out_in = '0;
      for (int b = 0; b < TaskWidth; b++) begin
         if (b < TASK_ID_WIDTH) task_out_in[b] = acc_c[QUEUE_DEPTH][b];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff   <= status_in;
         task_out_ff <= task_out_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = status_ff;
   assign rsp.task_out = task_out_ff;

   // Occupied cells always form an unbroken run from the head.
   a_packed_run : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("queue cells not packed towards the head");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      insert_en |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("enqueue did not add exactly one entry");

   a_remove_shrinks : assert property (@(posedge clock) disable iff (reset)
      remove_en |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
      else $error("take-out did not drop exactly one entry");

   a_single_update : assert property (@(posedge clock) disable iff (reset)
      !(insert_en && remove_en))
      else $error("insert and take-out in the same pass");

endmodule

### sim/pwq_checker.sv
module pwq_checker #(
   parameter int QUEUE_DEPTH   = pwq_pkg::QueueDepthDefault,
   parameter int TASK_ID_WIDTH = pwq_pkg::TaskIdWidthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [pwq_pkg::ModeWidth-1:0]   req_mode,
   input  logic [pwq_pkg::TaskWidth-1:0]   req_task_id,
   input  logic [pwq_pkg::PrioWidth-1:0]   req_priority,
   input  logic [pwq_pkg::LabelWidth-1:0]  req_label,
   input  logic [pwq_pkg::LabelWidth-1:0]  req_filter,
   input  logic [pwq_pkg::LabelWidth-1:0]  req_key,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [pwq_pkg::StatusWidth-1:0] rsp_status,
   input  logic [pwq_pkg::TaskWidth-1:0]   rsp_task_out,
   output int                              fail_count,
   output int                              pending_count
);
   import pwq_pkg::*;

   localparam logic [TaskWidth-1:0] IdMask = TaskWidth'((1 << TASK_ID_WIDTH) - 1);

   typedef struct {
      logic [TaskWidth-1:0]  task_id;
      logic [PrioWidth-1:0]  prio;
      logic [LabelWidth-1:0] label;
      logic [LabelWidth-1:0] filter;
   } waiter_type;

   typedef struct packed {
      status_type           status;
      logic [TaskWidth-1:0] task_out;
   } wait_result_type;

   waiter_type      waiters[$];
   wait_result_type awaited_results[$];
   int              errors = 0;

   // Apply one transaction to the shadow table and return the response it earns.
   function automatic wait_result_type run_wait_op(
      input logic [ModeWidth-1:0]  mode,
      input logic [TaskWidth-1:0]  id,
      input logic [PrioWidth-1:0]  prio,
      input logic [LabelWidth-1:0] label,
      input logic [LabelWidth-1:0] filter,
      input logic [LabelWidth-1:0] key
   );
      wait_result_type result;
      waiter_type      fresh;
      int              pos;
      int              found;
      bit              hit;
      result.status   = STATUS_NONE;
      result.task_out = '0;
      found = -1;
      if (mode == MODE_ENQUEUE) begin
         if (waiters.size() >= QUEUE_DEPTH) begin
            result.status = STATUS_FULL;
         end else begin
            fresh.task_id = id & IdMask;
            fresh.prio    = prio;
            fresh.label   = label;
            fresh.filter  = filter;
            pos = 0;
            // equal priority goes behind: keep arrival order
            while (pos < waiters.size() && waiters[pos].prio >= prio) pos++;
            waiters.insert(pos, fresh);
            result.status = STATUS_OK;
         end
      end else if (mode <= MODE_RECV_MATCH) begin
         foreach (waiters[i]) begin
            case (mode)
               MODE_DEQUEUE:    hit = 1'b1;
               MODE_REMOVE:     hit = (waiters[i].task_id == (id & IdMask));
               MODE_SEND_MATCH: hit = (key == '0) || (waiters[i].label == key);
               default:         hit = (waiters[i].filter == '0) || (waiters[i].filter == key);
            endcase
            if (hit && found < 0) found = i;
         end
         if (found >= 0) begin
            result.status   = STATUS_OK;
            result.task_out = waiters[found].task_id;
            waiters.delete(found);
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin
      wait_result_type want;
      if (reset) begin
         waiters.delete();
         awaited_results.delete();
      end else begin
         // take the response before the request: a response can never belong to
         // a request accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected response: expected none, got status %0d task %0d",
                        $time, rsp_status, rsp_task_out);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_task_out !== want.task_out) begin
                  $display("%0t: task_out mismatch: expected %0d, got %0d",
                           $time, want.task_out, rsp_task_out);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(run_wait_op(req_mode, req_task_id, req_priority,
                                                  req_label, req_filter, req_key));
      end
      fail_count    <= errors;
      pending_count <= awaited_results.size();
   end

endmodule

### sim/tb.sv
module tb;
   import pwq_pkg::*;

   localparam int RandomItems = 1050;
   localparam int QuietFrom   = 200;
   localparam int QuietTo     = 300;
   localparam int HoldAfter   = 400;
   localparam int HoldCycles  = 300;
   localparam int DrainAt     = 700;
   localparam int PhaseLen    = 60;

   logic clock;
   logic reset;
   int   sent_count = 0;
   bit   drained    = 0;
   bit   held       = 0;
   int   fail_count;
   int   pending_count;

   logic [LabelWidth-1:0] label_pool[8];
   logic [PrioWidth-1:0]  prio_pool[4];
   logic [TaskWidth-1:0]  recent_ids[16];

   pwq_req_if req_if();
   pwq_rsp_if rsp_if();

   priority_wait_queue_label_match u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   pwq_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_mode      (req_if.mode),
      .req_task_id   (req_if.task_id),
      .req_priority  (req_if.priority_req),
      .req_label     (req_if.msg_label),
      .req_filter    (req_if.recv_filter),
      .req_key       (req_if.match_key),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_status    (rsp_if.status),
      .rsp_task_out  (rsp_if.task_out),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

   function automatic bit quiet_stretch();
      return sent_count >= QuietFrom && sent_count < QuietTo;
   endfunction

   function automatic logic [LabelWidth-1:0] pick_word(input int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return '0;
      if (r < zero_pct + 5) return '1;
      if (r < 75) return label_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic send_item(
      input logic [ModeWidth-1:0]  mode,
      input logic [TaskWidth-1:0]  id,
      input logic [PrioWidth-1:0]  prio,
      input logic [LabelWidth-1:0] label,
      input logic [LabelWidth-1:0] filter,
      input logic [LabelWidth-1:0] key
   );
      int gap;
      bit pause;
      gap   = quiet_stretch() ? 0 : $urandom_range(0, 4);
      pause = (sent_count >= DrainAt) && !drained;
      if (pause || gap > 0) begin
         req_if.valid <= 1'b0;
         // hold until every outstanding response has been taken
         if (pause) begin
            drained = 1'b1;
            do @(posedge clock); while (pending_count != 0);
         end
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.mode         <= mode;
      req_if.task_id      <= id;
      req_if.priority_req <= prio;
      req_if.msg_label    <= label;
      req_if.recv_filter  <= filter;
      req_if.match_key    <= key;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   // response side: random back-pressure, one long hold-off to fill the block
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!held && sent_count >= HoldAfter) begin
            held = 1'b1;
            gap  = HoldCycles;
         end else begin
            gap = quiet_stretch() ? 0 : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      int                    used;
      int                    enq_pct;
      int                    r;
      logic [ModeWidth-1:0]  m;
      logic [TaskWidth-1:0]  id;
      logic [PrioWidth-1:0]  prio;
      logic [LabelWidth-1:0] lab_d;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.mode         <= MODE_ENQUEUE;
      req_if.task_id      <= '0;
      req_if.priority_req <= '0;
      req_if.msg_label    <= '0;
      req_if.recv_filter  <= '0;
      req_if.match_key    <= '0;

      foreach (label_pool[i]) label_pool[i] = $urandom;
      prio_pool[0] = '0;
      prio_pool[1] = '1;
      prio_pool[2] = PrioWidth'($urandom);
      prio_pool[3] = PrioWidth'($urandom);
      foreach (recent_ids[i]) recent_ids[i] = TaskWidth'($urandom);
      lab_d = 32'h1357_9bdf;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table: every take-out misses, unused modes are ignored
      send_item(MODE_DEQUEUE, 8'd3, '0, '0, '0, '0);
      send_item(MODE_REMOVE, 8'd3, '0, '0, '0, '0);
      send_item(MODE_SEND_MATCH, '0, '0, '0, '0, '0);
      send_item(MODE_RECV_MATCH, '0, '0, '0, '0, '1);
      send_item(ModeWidth'(MODE_RECV_MATCH + 1), '0, '0, '0, '0, '0);
      send_item('1, '1, '1, '1, '1, '1);
      // extremes, a priority tie and a duplicate task
      send_item(MODE_ENQUEUE, '0, '0, '0, '0, '0);
      send_item(MODE_ENQUEUE, '1, '1, '1, '1, '0);
      send_item(MODE_ENQUEUE, 8'd7, '1, 32'haaaa_5555, 32'h5555_aaaa, '0);
      send_item(MODE_ENQUEUE, 8'd7, 8'h80, lab_d, 32'h0000_0055, '0);
      send_item(MODE_SEND_MATCH, '0, '0, '0, '0, '0);
      send_item(MODE_REMOVE, 8'd7, '0, '0, '0, '0);
      send_item(MODE_REMOVE, 8'd99, '0, '0, '0, '0);
      send_item(MODE_SEND_MATCH, '0, '0, '0, '0, lab_d);
      send_item(MODE_SEND_MATCH, '0, '0, '0, '0, 32'hdead_beef);
      send_item(MODE_RECV_MATCH, '0, '0, '0, '0, 32'h0000_0042);
      send_item(MODE_ENQUEUE, 8'd12, 8'd5, lab_d, 32'h0000_1234, '0);
      send_item(MODE_RECV_MATCH, '0, '0, '0, '0, 32'h0000_1234);
      send_item(MODE_ENQUEUE, 8'd13, 8'd5, lab_d, 32'h0000_0005, '0);
      send_item(MODE_RECV_MATCH, '0, '0, '0, '0, 32'h0000_0006);
      send_item(ModeWidth'(MODE_RECV_MATCH + 2), 8'd13, '0, '0, '0, '0);
      send_item(MODE_DEQUEUE, '0, '0, '0, '0, '0);

      // alternate fill and drain phases so the table runs full and empty often
      used = 0;
      while (used < RandomItems) begin
         enq_pct = ((used / PhaseLen) % 2 == 0) ? 60 : 25;
         r  = $urandom_range(0, 99);
         id = TaskWidth'($urandom);
         if (r < 2) begin
            m = ModeWidth'($urandom_range(int'(MODE_RECV_MATCH) + 1, (1 << ModeWidth) - 1));
         end else if (r < 2 + enq_pct) begin
            m = MODE_ENQUEUE;
         end else begin
            case ($urandom_range(0, 3))
               0:       m = MODE_DEQUEUE;
               1:       m = MODE_REMOVE;
               2:       m = MODE_SEND_MATCH;
               default: m = MODE_RECV_MATCH;
            endcase
         end
         if (m == MODE_ENQUEUE)
            recent_ids[$urandom_range(0, 15)] = id;
         else if (m == MODE_REMOVE && $urandom_range(0, 9) < 7)
            id = recent_ids[$urandom_range(0, 15)];
         prio = ($urandom_range(0, 9) < 6) ? prio_pool[$urandom_range(0, 3)]
                                           : PrioWidth'($urandom);
         if (m <= MODE_RECV_MATCH) used++;
         send_item(m, id, prio, pick_word(10), pick_word(25), pick_word(20));
      end
      req_if.valid <= 1'b0;

      // let the count take in the last accepted transaction before waiting on it
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
